FILE: rtl/pcs_pkg.sv
// Shared widths and types for the smootherstep pixel crossfade.
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned AMOUNT_W = 17;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [AMOUNT_W-1:0] amount_t;

endpackage

FILE: rtl/pixel_crossfade_smootherstep.sv
// Smootherstep-eased crossfade of two pixel channel streams.
//
// Request channel: in_valid_i / in_stall_o carry one channel byte of the
// outgoing frame and the matching byte of the incoming frame. Result channel:
// out_valid_o / out_stall_i carry the blended byte, one per request, in order.
// A request moves at a clock edge where valid is high and stall is low.
// Throughput is one request per cycle while in_stall_o is low; a taken
// request passes the input register, then the result register, after which
// out_valid_o rises and the result can leave.
// cfg_we_i / cfg_wdata_i write the blend amount (Q1.FRAC_BITS, clamped to one).
// The eased weight is rebuilt by a six-stage multiply pipeline; in_stall_o is
// held high during the write cycle and while that pipeline is busy.
// Reset clears the weight to zero (output equals the outgoing byte) and
// empties both stages. A stalled valid result holds in the result register;
// an empty input register takes one more request, then in_stall_o rises.
`timescale 1ns / 1ps

module pixel_crossfade_smootherstep #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  pcs_pkg::amount_t      cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pcs_pkg::chan_t        from_channel_i,
  input  pcs_pkg::chan_t        to_channel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pcs_pkg::chan_t        blended_channel_o
);

  localparam int unsigned AW     = FRAC_BITS + 1;
  localparam int unsigned CW     = (AW > pcs_pkg::AMOUNT_W) ? AW : pcs_pkg::AMOUNT_W;
  localparam int unsigned SW     = 2 * AW;
  localparam int unsigned GW     = FRAC_BITS + 4;
  localparam int unsigned QW     = 2 * FRAC_BITS + 5;
  localparam int unsigned PW     = AW + GW;
  localparam int unsigned ACC_W  = FRAC_BITS + 11;
  localparam int unsigned STAGES = 6;

  localparam logic [AW-1:0]  ONE      = AW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]  ONE_C    = CW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]  HALF_Q   = QW'(1) << (FRAC_BITS - 1);
  localparam logic [QW-1:0]  TEN_ONE2 = QW'(10) << (2 * FRAC_BITS);
  localparam logic [ACC_W-1:0] HALF_A = ACC_W'(1) << (FRAC_BITS - 1);

  // ---------------- weight easing pipeline ----------------
  logic [STAGES-1:0] ease_pipe_q, ease_pipe_d;
  logic              ease_busy;
  logic [AW-1:0]     a_q, a_d;
  logic [SW-1:0]     sq_q;
  logic [AW-1:0]     c2_q, c2_d;
  logic [GW-1:0]     g_q, g_d;
  logic [SW-1:0]     p3_q;
  logic [AW-1:0]     c3_q, c3_d;
  logic [PW-1:0]     p4_q;
  logic [AW-1:0]     weight_q, weight_d;
  logic [QW-1:0]     quad;
  logic [QW-1:0]     w_sum;

  assign ease_pipe_d = {ease_pipe_q[STAGES-2:0], cfg_we_i};
  assign ease_busy   = |ease_pipe_q;

  always_comb begin
    if (CW'(cfg_wdata_i) > ONE_C) begin
      a_d = ONE;
    end else begin
      a_d = AW'(cfg_wdata_i);
    end
  end

  // g = rnd(6a^2 + 10*ONE^2 - 15*a*ONE), c2 = rnd(a^2)
  always_comb begin
    quad  = (QW'(sq_q) << 2) + (QW'(sq_q) << 1) + TEN_ONE2
            - (((QW'(a_q) << 4) - QW'(a_q)) << FRAC_BITS);
    g_d   = GW'((quad + HALF_Q) >> FRAC_BITS);
    c2_d  = AW'((QW'(sq_q) + HALF_Q) >> FRAC_BITS);
    c3_d  = AW'((QW'(p3_q) + HALF_Q) >> FRAC_BITS);
    w_sum = (QW'(p4_q) + HALF_Q) >> FRAC_BITS;
    if (w_sum > QW'(ONE)) begin
      weight_d = ONE;
    end else begin
      weight_d = AW'(w_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      a_q <= a_d;
    end
    sq_q <= SW'(a_q) * SW'(a_q);
    c2_q <= c2_d;
    g_q  <= g_d;
    p3_q <= SW'(c2_q) * SW'(a_q);
    c3_q <= c3_d;
    p4_q <= PW'(c3_q) * PW'(g_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ease_pipe_q <= '0;
      weight_q    <= '0;
    end else begin
      ease_pipe_q <= ease_pipe_d;
      if (ease_pipe_q[STAGES-1]) begin
        weight_q <= weight_d;
      end
    end
  end

  // ---------------- pixel datapath ----------------
  logic                   s1_valid_q;
  pcs_pkg::chan_t         from_q, to_q;
  logic                   out_valid_q;
  pcs_pkg::chan_t         blend_q, blend_d;
  logic                   out_ready, s1_ready, in_take;
  logic signed [8:0]      diff;
  logic signed [AW:0]     w_s;
  logic signed [ACC_W-1:0] prod, base, acc;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready || ease_busy || cfg_we_i;
  assign in_take   = in_valid_i && !in_stall_o;

  // from + (to - from) * w, rounded half up
  always_comb begin
    diff    = $signed({1'b0, to_q}) - $signed({1'b0, from_q});
    w_s     = $signed({1'b0, weight_q});
    prod    = ACC_W'(diff) * ACC_W'(w_s);
    base    = $signed({3'b000, from_q, {FRAC_BITS{1'b0}}});
    acc     = base + prod + $signed(HALF_A);
    blend_d = acc[FRAC_BITS+7:FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      from_q <= from_channel_i;
      to_q   <= to_channel_i;
    end
    if (s1_valid_q && out_ready) begin
      blend_q <= blend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_take;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign blended_channel_o = blend_q;

  // ---------------- assertions ----------------
  a_stall_while_easing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ease_busy |-> in_stall_o)
    else $error("request accepted while weight is being rebuilt");

  a_weight_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    weight_q <= ONE)
    else $error("eased weight above one");

  a_write_starts_ease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> ease_pipe_q[0])
    else $error("config write did not start easing pipeline");

  a_take_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted request lost at input register");

  a_no_req_during_ease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ease_pipe_q[STAGES-1] |-> !s1_valid_q)
    else $error("request in flight while weight updates");

endmodule
